/* rtl/bba_pkg.sv */
// Shared types, codes and constants of the bitmap block allocator.
package bba_pkg;

  localparam int MAX_BLOCKS_DEF = 4096;
  localparam int RESERVED_DEF   = 16;

  localparam int BLOCK_W    = 12;
  localparam int SIZE_CFG_W = 13;

  localparam logic [SIZE_CFG_W-1:0] SIZE_RESET = 13'd4096;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_INVALID = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_FREE_RD,
    S_FREE_WR,
    S_RESP
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic clr;
    logic start;
    logic scan;
    logic free_rd;
    logic free_wr;
    logic push;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic clr_last;
    logic is_free;
    logic quick;
    logic hit;
    logic exhausted;
    logic out_free;
  } dp_st_t;

endpackage

/* rtl/bba_req_if.sv */
// Request channel: operation and block number.
interface bba_req_if;
  import bba_pkg::*;

  logic               valid;
  logic               ready;
  logic               op;
  logic [BLOCK_W-1:0] block;

  modport source (output valid, output op, output block, input ready);
  modport sink   (input valid, input op, input block, output ready);
endinterface

/* rtl/bba_rsp_if.sv */
// Response channel: status and granted block.
interface bba_rsp_if;
  import bba_pkg::*;

  logic               valid;
  logic               ready;
  status_t            status;
  logic [BLOCK_W-1:0] granted_block;

  modport source (output valid, output status, output granted_block, input ready);
  modport sink   (input valid, input status, input granted_block, output ready);
endinterface

/* rtl/bba_ram.sv */
// Generic simple dual-port RAM with registered read.
module bba_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                       wr_data,
  input  logic                                   rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* rtl/bba_ctrl.sv */
// Controller state machine: sequences clearing, scan, free and response.
module bba_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output bba_pkg::dp_cmd_t  cmd,
  input  bba_pkg::dp_st_t   st
);
  import bba_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: begin
        if (st.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          if (st.quick)        state_nxt = S_RESP;
          else if (st.is_free) state_nxt = S_FREE_RD;
          else                 state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (st.hit || st.exhausted) state_nxt = S_RESP;
      end
      S_FREE_RD: state_nxt = S_FREE_WR;
      S_FREE_WR: state_nxt = S_RESP;
      S_RESP: begin
        if (st.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      S_CLEAR:   cmd.clr = 1'b1;
      S_IDLE: begin
        in_ready  = 1'b1;
        cmd.start = in_valid;
      end
      S_SCAN:    cmd.scan    = 1'b1;
      S_FREE_RD: cmd.free_rd = 1'b1;
      S_FREE_WR: cmd.free_wr = 1'b1;
      S_RESP:    cmd.push    = st.out_free;
      default:   cmd         = '0;
    endcase
  end

endmodule

/* rtl/bba_dpath.sv */
// Datapath: used map RAM, word scan pipeline, pointer, result and output register.
module bba_dpath #(
  parameter int MAX_BLOCKS      = bba_pkg::MAX_BLOCKS_DEF,
  parameter int RESERVED_BLOCKS = bba_pkg::RESERVED_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [bba_pkg::SIZE_CFG_W-1:0]    cfg_wdata,
  input  logic                              in_op,
  input  logic [bba_pkg::BLOCK_W-1:0]       in_block,
  input  bba_pkg::dp_cmd_t                  cmd,
  output bba_pkg::dp_st_t                   st,
  output logic                              out_valid,
  input  logic                              out_ready,
  output bba_pkg::status_t                  out_status,
  output logic [bba_pkg::BLOCK_W-1:0]       out_granted
);
  import bba_pkg::*;

  // MAX_BLOCKS is a power of two
  localparam int BW       = $clog2(MAX_BLOCKS);
  localparam int SW       = BW + 1;
  localparam int WORD_W   = (MAX_BLOCKS >= 128) ? 64 : 16;
  localparam int OW       = $clog2(WORD_W);
  localparam int NWORDS   = MAX_BLOCKS / WORD_W;
  localparam int AW       = BW - OW;
  localparam int CW       = (SW > SIZE_CFG_W) ? SW : SIZE_CFG_W;
  localparam int FIRST    = RESERVED_BLOCKS + 1;
  localparam int RES_WORD = RESERVED_BLOCKS / WORD_W;
  localparam int RES_BIT  = RESERVED_BLOCKS % WORD_W;
  localparam logic [WORD_W-1:0] RES_MASK = {WORD_W{1'b1}} >> (WORD_W - 1 - RES_BIT);
  localparam logic [SW-1:0]     FIRST_S  = SW'(FIRST);

  // configuration and pointer
  logic [SIZE_CFG_W-1:0] dev_blocks_r;
  logic [BW-1:0]         ptr_r;

  // per-item registers
  logic [SW-1:0]  size_r;
  logic [BW-1:0]  p0_r;
  logic [BW-1:0]  free_blk_r;
  status_t        res_status_r;
  logic [BLOCK_W-1:0] res_grant_r;

  // scan pipeline: issue stage and evaluate stage
  logic          iss_act_r, iss_act_nxt;
  logic [AW-1:0] iss_w_r, iss_w_nxt;
  logic          iss_wrap_r, iss_wrap_nxt;
  logic          ev_valid_r, ev_valid_nxt;
  logic [AW-1:0] ev_w_r;
  logic          ev_wrap_r;
  logic          ev_last_r;

  logic [AW-1:0] clr_w_r;

  logic          out_valid_r;
  status_t       out_status_r;
  logic [BLOCK_W-1:0] out_grant_r;

  // RAM port signals
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [WORD_W-1:0] wr_data;
  logic              rd_en;
  logic [AW-1:0]     rd_addr;
  logic [WORD_W-1:0] rd_data;

  // ---------------- item start ----------------
  logic [CW-1:0] size_cw;
  logic [SW-1:0] size_c;
  logic          tiny;
  logic [CW-1:0] blk_cw;
  logic          blk_bad;
  logic          is_free;
  logic [BW-1:0] p0_c;

  always_comb begin
    size_cw = (CW'(dev_blocks_r) < CW'(MAX_BLOCKS)) ? CW'(dev_blocks_r) : CW'(MAX_BLOCKS);
    size_c  = size_cw[SW-1:0];
    tiny    = size_c <= FIRST_S;
    blk_cw  = CW'(in_block);
    blk_bad = (blk_cw < CW'(FIRST)) || (blk_cw >= CW'(size_c));
    is_free = in_op == OP_FREE;
    if ((SW'(ptr_r) < FIRST_S) || (SW'(ptr_r) >= size_c)) p0_c = FIRST_S[BW-1:0];
    else                                                  p0_c = ptr_r;
  end

  // ---------------- issue stage ----------------
  logic [SW-1:0] size_m1;
  logic [AW-1:0] last_w;
  logic [AW-1:0] start_w;
  logic [AW-1:0] first_w;
  logic          final_iss;

  assign size_m1   = size_r - SW'(1);
  assign last_w    = size_m1[BW-1:OW];
  assign start_w   = p0_r[BW-1:OW];
  assign first_w   = FIRST_S[BW-1:OW];
  assign final_iss = iss_wrap_r && (iss_w_r == start_w);

  // ---------------- evaluate stage ----------------
  logic [SW-1:0]     lo, hi;
  logic [AW:0]       ev_w_ext;
  logic [OW:0]       lo_off, hi_off;
  logic [WORD_W-1:0] cand;
  logic [OW-1:0]     pos;
  logic              hit_c;
  logic              exhausted_c;
  logic [BW-1:0]     grant;
  logic [SW-1:0]     gnext;
  logic [BW-1:0]     ptr_nxt;

  always_comb begin
    lo       = ev_wrap_r ? FIRST_S : SW'(p0_r);
    hi       = ev_wrap_r ? SW'(p0_r) : size_r;
    ev_w_ext = {1'b0, ev_w_r};
    if (lo[SW-1:OW] > ev_w_ext)       lo_off = (OW+1)'(WORD_W);
    else if (lo[SW-1:OW] == ev_w_ext) lo_off = {1'b0, lo[OW-1:0]};
    else                              lo_off = '0;
    if (hi[SW-1:OW] > ev_w_ext)       hi_off = (OW+1)'(WORD_W);
    else if (hi[SW-1:OW] == ev_w_ext) hi_off = {1'b0, hi[OW-1:0]};
    else                              hi_off = '0;
    for (int i = 0; i < WORD_W; i++) begin
      cand[i] = !rd_data[i] && ((OW+1)'(i) >= lo_off) && ((OW+1)'(i) < hi_off);
    end
    pos = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (cand[i]) pos = OW'(i);
    end
    hit_c       = ev_valid_r && (|cand);
    exhausted_c = ev_valid_r && !(|cand) && ev_last_r;
    grant       = {ev_w_r, pos};
    gnext       = SW'(grant) + SW'(1);
    ptr_nxt     = (gnext >= size_r) ? FIRST_S[BW-1:0] : gnext[BW-1:0];
  end

  always_comb begin
    iss_act_nxt  = iss_act_r;
    iss_w_nxt    = iss_w_r;
    iss_wrap_nxt = iss_wrap_r;
    ev_valid_nxt = ev_valid_r;
    if (cmd.start) begin
      iss_act_nxt  = 1'b1;
      iss_w_nxt    = p0_c[BW-1:OW];
      iss_wrap_nxt = 1'b0;
      ev_valid_nxt = 1'b0;
    end else if (cmd.scan) begin
      if (hit_c || exhausted_c) begin
        iss_act_nxt  = 1'b0;
        ev_valid_nxt = 1'b0;
      end else begin
        ev_valid_nxt = iss_act_r;
        if (iss_act_r) begin
          iss_act_nxt = !final_iss;
          if (!iss_wrap_r && (iss_w_r == last_w)) begin
            iss_w_nxt    = first_w;
            iss_wrap_nxt = 1'b1;
          end else begin
            iss_w_nxt = iss_w_r + AW'(1);
          end
        end
      end
    end
  end

  // ---------------- RAM ports ----------------
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = ev_w_r;
    wr_data = rd_data;
    if (cmd.clr) begin
      wr_en   = 1'b1;
      wr_addr = clr_w_r;
      if (32'(clr_w_r) < 32'(RES_WORD))       wr_data = '1;
      else if (32'(clr_w_r) == 32'(RES_WORD)) wr_data = RES_MASK;
      else                                    wr_data = '0;
    end else if (cmd.scan && hit_c) begin
      wr_en   = 1'b1;
      wr_addr = ev_w_r;
      wr_data = rd_data | (WORD_W'(1) << pos);
    end else if (cmd.free_wr) begin
      wr_en   = 1'b1;
      wr_addr = free_blk_r[BW-1:OW];
      wr_data = rd_data & ~(WORD_W'(1) << free_blk_r[OW-1:0]);
    end
  end

  assign rd_en   = (cmd.scan && iss_act_r) || cmd.free_rd;
  assign rd_addr = cmd.free_rd ? free_blk_r[BW-1:OW] : iss_w_r;

  bba_ram #(
    .WIDTH (WORD_W),
    .DEPTH (NWORDS)
  ) u_map (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // ---------------- control registers ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_blocks_r <= SIZE_RESET;
      ptr_r        <= BW'(1);
      iss_act_r    <= 1'b0;
      ev_valid_r   <= 1'b0;
      clr_w_r      <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) dev_blocks_r <= cfg_wdata;
      if (cmd.scan && hit_c) ptr_r <= ptr_nxt;
      iss_act_r  <= iss_act_nxt;
      ev_valid_r <= ev_valid_nxt;
      if (cmd.clr) clr_w_r <= clr_w_r + AW'(1);
      if (cmd.push)       out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  // ---------------- payload registers ----------------
  always_ff @(posedge clk) begin
    iss_w_r    <= iss_w_nxt;
    iss_wrap_r <= iss_wrap_nxt;
    if (cmd.scan) begin
      ev_w_r    <= iss_w_r;
      ev_wrap_r <= iss_wrap_r;
      ev_last_r <= final_iss;
    end
    if (cmd.start) begin
      size_r      <= size_c;
      p0_r        <= p0_c;
      free_blk_r  <= blk_cw[BW-1:0];
      res_grant_r <= '0;
      if (is_free)   res_status_r <= blk_bad ? ST_INVALID : ST_OK;
      else           res_status_r <= tiny ? ST_FULL : ST_OK;
    end else if (cmd.scan && hit_c) begin
      res_grant_r  <= BLOCK_W'(grant);
      res_status_r <= ST_OK;
    end else if (cmd.scan && exhausted_c) begin
      res_status_r <= ST_FULL;
    end
    if (cmd.push) begin
      out_status_r <= res_status_r;
      out_grant_r  <= res_grant_r;
    end
  end

  // ---------------- status and outputs ----------------
  always_comb begin
    st.clr_last  = clr_w_r == AW'(NWORDS - 1);
    st.is_free   = is_free;
    st.quick     = is_free ? blk_bad : tiny;
    st.hit       = hit_c;
    st.exhausted = exhausted_c;
    st.out_free  = !out_valid_r || out_ready;
  end

  assign out_valid   = out_valid_r;
  assign out_status  = out_status_r;
  assign out_granted = out_grant_r;

endmodule

/* rtl/bitmap_block_allocator.sv */
// Top level of the next-fit bitmap block allocator.
//
// Request channel in_ch carries op (allocate or free) and block; response
// channel out_ch carries status and granted_block, one response per request.
// cfg_we/cfg_wdata write the device size; write only while the block is idle.
// The used map sits in a RAM of 64-bit words (16-bit below 128 blocks).
// Allocate scans one map word per cycle from the search pointer, wrapping
// past the reserved blocks. Free reads and rewrites one word. Requests that
// fail their range check answer without touching the map.
// One request is in flight at a time; the next is taken as soon as the
// response sits in the output register, so a stalled receiver holds only
// that one response while the next request is worked on.
// After reset the map is cleared word by word with the reserved blocks
// marked used; in_ch.ready stays low during that pass. The pointer resets
// to 1 and the size to 4096.
module bitmap_block_allocator #(
  parameter int MAX_BLOCKS      = bba_pkg::MAX_BLOCKS_DEF,
  parameter int RESERVED_BLOCKS = bba_pkg::RESERVED_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  bba_req_if.sink                        in_ch,
  bba_rsp_if.source                      out_ch,
  input  logic                           cfg_we,
  input  logic [bba_pkg::SIZE_CFG_W-1:0] cfg_wdata
);
  import bba_pkg::*;

  dp_cmd_t cmd;
  dp_st_t  st;

  bba_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .cmd      (cmd),
    .st       (st)
  );

  bba_dpath #(
    .MAX_BLOCKS      (MAX_BLOCKS),
    .RESERVED_BLOCKS (RESERVED_BLOCKS)
  ) u_dpath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .in_op       (in_ch.op),
    .in_block    (in_ch.block),
    .cmd         (cmd),
    .st          (st),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .out_status  (out_ch.status),
    .out_granted (out_ch.granted_block)
  );

endmodule

/* rtl/bba_checker.sv */
// Port-level checker for the allocator, bound to the top level.
module bba_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input bba_pkg::status_t            out_status,
  input logic [bba_pkg::BLOCK_W-1:0] out_granted
);
  import bba_pkg::*;

  // map clearing pass keeps requests out right after reset
  a_clear_after_reset: assert property (@(posedge clk)
    $past(!rst_n) |-> !in_ready)
    else $error("request side ready during map clearing");

  // one request at a time: busy in the cycle after a transfer
  a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second request taken while one is in flight");

  a_fail_no_grant: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status != ST_OK)) |-> (out_granted == '0))
    else $error("failed response carries a block number");

  a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(out_status) && $stable(out_granted)))
    else $error("stalled response changed or dropped");

endmodule

bind bitmap_block_allocator bba_checker u_bba_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_status  (out_ch.status),
  .out_granted (out_ch.granted_block)
);

/* dv/bitmap_block_allocator_tb.sv */
// Self-checking testbench for the next-fit bitmap block allocator.
module bitmap_block_allocator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bba_pkg::*;

  localparam int FIRST_USABLE  = RESERVED_DEF + 1;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int SETTLE_CYCLES = 80;    // beyond the worst-case full scan
  localparam int RANDOM_ITEMS  = 1400;
  localparam int HOLD_CYCLES   = 400;

  typedef struct packed {
    status_t            status;
    logic [BLOCK_W-1:0] granted_block;
  } alloc_rsp_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [SIZE_CFG_W-1:0] cfg_wdata;

  bba_req_if in_if ();
  bba_rsp_if out_if ();

  bitmap_block_allocator uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_if),
    .out_ch    (out_if),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // Shadow copy of the allocator state
  logic [MAX_BLOCKS_DEF-1:0] used_bits;
  int unsigned               search_ptr;
  logic [SIZE_CFG_W-1:0]     dev_size;

  alloc_rsp_t pending_rsp[$];
  int         held_blocks[$];
  int         fail_count    = 0;
  int         cycle_count   = 0;
  bit         tx_gaps_on    = 1'b1;
  bit         rx_gaps_on    = 1'b1;
  int         hold_requests = 0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("[bitmap_block_allocator] ERROR");
    $finish;
  end

  task automatic model_request(input logic op, input logic [BLOCK_W-1:0] blk,
                               output alloc_rsp_t rsp);
    int unsigned size;
    int unsigned p;
    int unsigned n;
    bit          found;
    size  = (dev_size < MAX_BLOCKS_DEF) ? dev_size : MAX_BLOCKS_DEF;
    found = 1'b0;
    rsp.status        = ST_OK;
    rsp.granted_block = '0;
    if (op == OP_FREE) begin
      if (blk < FIRST_USABLE || blk >= size) rsp.status = ST_INVALID;
      else used_bits[blk] = 1'b0;
    end else if (size <= FIRST_USABLE) begin
      rsp.status = ST_FULL;
    end else begin
      p = search_ptr;
      if (p < FIRST_USABLE || p >= size) p = FIRST_USABLE;
      for (n = 0; n < size - FIRST_USABLE && !found; n++) begin
        if (!used_bits[p]) begin
          found             = 1'b1;
          used_bits[p]      = 1'b1;
          rsp.granted_block = p[BLOCK_W-1:0];
          search_ptr        = (p + 1 >= size) ? FIRST_USABLE : p + 1;
          held_blocks.push_back(p);
        end else begin
          p++;
          if (p >= size) p = FIRST_USABLE;
        end
      end
      if (!found) rsp.status = ST_FULL;
    end
  endtask

  // One request transfer; valid is only lowered when a gap is drawn
  task automatic send_req(input logic op, input logic [BLOCK_W-1:0] blk);
    int         gap;
    alloc_rsp_t rsp;
    gap = tx_gaps_on ? $urandom_range(0, 11) : 0;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.op    <= op;
    in_if.block <= blk;
    do @(posedge clk); while (!in_if.ready);
    model_request(op, blk, rsp);
    pending_rsp.push_back(rsp);
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_size(input logic [SIZE_CFG_W-1:0] size);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= size;
    @(posedge clk);
    cfg_we    <= 1'b0;
    dev_size  = size;
  endtask

  initial begin : rsp_checker
    alloc_rsp_t want;
    int         rsp_gap;
    int         rx_hold;
    int         holds_seen;
    rsp_gap    = 0;
    rx_hold    = 0;
    holds_seen = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_requests != holds_seen) begin
        holds_seen = hold_requests;
        rx_hold    = HOLD_CYCLES;
      end
      if (rst_n && out_if.valid && out_if.ready) begin
        if (pending_rsp.size() == 0) begin
          $error("unexpected response: status %0d granted_block %0d",
                 out_if.status, out_if.granted_block);
          fail_count++;
        end else begin
          want = pending_rsp.pop_front();
          if (out_if.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, out_if.status);
            fail_count++;
          end
          if (out_if.granted_block !== want.granted_block) begin
            $error("granted_block: expected %0d, actual %0d",
                   want.granted_block, out_if.granted_block);
            fail_count++;
          end
        end
        rsp_gap = rx_gaps_on ? $urandom_range(0, 11) : 0;
      end else if (rsp_gap > 0) begin
        rsp_gap--;
      end
      if (rx_hold > 0) begin
        rx_hold--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= (rsp_gap == 0);
      end
    end
  end

  task automatic test_reset_state();
    send_req(OP_ALLOC, '0);
    send_req(OP_ALLOC, '1);           // block field ignored on allocate
    send_req(OP_FREE, BLOCK_W'(0));
    send_req(OP_FREE, BLOCK_W'(RESERVED_DEF));
    send_req(OP_FREE, BLOCK_W'(FIRST_USABLE));
    send_req(OP_FREE, BLOCK_W'(FIRST_USABLE));  // already clear
    send_req(OP_FREE, BLOCK_W'(MAX_BLOCKS_DEF - 1));
    send_req(OP_ALLOC, '0);           // next-fit: must not reuse the freed block
  endtask

  task automatic test_size_limits();
    set_size(SIZE_CFG_W'(FIRST_USABLE));   // no usable blocks
    send_req(OP_ALLOC, '0);
    send_req(OP_FREE, BLOCK_W'(FIRST_USABLE));
    set_size('0);
    send_req(OP_ALLOC, '0);
    set_size(SIZE_CFG_W'(FIRST_USABLE + 1));   // exactly one usable block
    send_req(OP_ALLOC, '0);
    send_req(OP_ALLOC, '0);
    send_req(OP_FREE, BLOCK_W'(FIRST_USABLE + 1));
    send_req(OP_FREE, BLOCK_W'(FIRST_USABLE));
    set_size('1);                          // clipped to the map size
    send_req(OP_FREE, BLOCK_W'(MAX_BLOCKS_DEF - 1));
    send_req(OP_ALLOC, '0);
  endtask

  task automatic test_full_wrap();
    set_size(SIZE_CFG_W'(FIRST_USABLE + 5));
    repeat (6) send_req(OP_ALLOC, '0);
    send_req(OP_FREE, BLOCK_W'(FIRST_USABLE + 4));
    send_req(OP_FREE, BLOCK_W'(FIRST_USABLE + 1));
    send_req(OP_ALLOC, '0);
    send_req(OP_ALLOC, '0);
  endtask

  // Receiver stalls while requests keep coming, so the input backs up
  task automatic test_backpressure();
    set_size(SIZE_RESET);
    tx_gaps_on = 1'b0;
    hold_requests++;
    repeat (12) send_req(OP_ALLOC, BLOCK_W'($urandom));
    repeat (6) send_req(OP_FREE, BLOCK_W'($urandom));
    repeat (6) send_req(OP_ALLOC, '0);
    drain();
    tx_gaps_on = 1'b1;
  endtask

  task automatic test_random_traffic();
    int sizes[$] = '{4096, 130, 18, 8191, 40, 1000, 64, 17, 300, 4095, 200, 19};
    int per_phase;
    int r;
    int k;
    int blk;
    per_phase = RANDOM_ITEMS / sizes.size();
    foreach (sizes[ph]) begin
      set_size(SIZE_CFG_W'(sizes[ph]));
      tx_gaps_on = (ph % 4 == 0) || (ph % 4 == 2);
      rx_gaps_on = (ph % 4 == 0) || (ph % 4 == 3);
      for (int i = 0; i < per_phase; i++) begin
        r = $urandom_range(0, 99);
        if (r < 50) begin
          send_req(OP_ALLOC, BLOCK_W'($urandom));
        end else if (r < 85 && held_blocks.size() > 0) begin
          k   = $urandom_range(0, held_blocks.size() - 1);
          blk = held_blocks[k];
          held_blocks.delete(k);
          send_req(OP_FREE, BLOCK_W'(blk));
        end else if (r < 92) begin
          // edges of the usable range
          case ($urandom_range(0, 3))
            0:       blk = FIRST_USABLE - 1;
            1:       blk = FIRST_USABLE;
            2:       blk = sizes[ph] - 1;
            default: blk = sizes[ph];
          endcase
          send_req(OP_FREE, BLOCK_W'(blk));
        end else begin
          send_req(OP_FREE, BLOCK_W'($urandom));
        end
      end
    end
    tx_gaps_on = 1'b1;
    rx_gaps_on = 1'b1;
  endtask

  initial begin : stimulus
    in_if.valid  <= 1'b0;
    in_if.op     <= OP_ALLOC;
    in_if.block  <= '0;
    cfg_we       <= 1'b0;
    cfg_wdata    <= '0;
    rst_n        <= 1'b0;
    used_bits  = '0;
    for (int b = 0; b <= RESERVED_DEF; b++) used_bits[b] = 1'b1;
    search_ptr = 1;
    dev_size   = SIZE_RESET;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_state();
    test_size_limits();
    test_full_wrap();
    test_backpressure();
    test_random_traffic();
    drain();

    if (fail_count == 0) begin
      $display("[bitmap_block_allocator] OK");
    end else begin
      $display("[bitmap_block_allocator] ERROR");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/bba_pkg.sv
rtl/bba_req_if.sv
rtl/bba_rsp_if.sv
rtl/bba_ram.sv
rtl/bba_ctrl.sv
rtl/bba_dpath.sv
rtl/bitmap_block_allocator.sv
rtl/bba_checker.sv
dv/bitmap_block_allocator_tb.sv
